/* hdl/tle_pkg.sv */
package tle_pkg;

	localparam int LineDepth = 32;

	localparam logic [7:0] ChEsc  = 8'd27;
	localparam logic [7:0] ChDel  = 8'd127;
	localparam logic [7:0] ChBs   = 8'd8;
	localparam logic [7:0] ChLf   = 8'd10;
	localparam logic [7:0] ChCr   = 8'd13;
	localparam logic [7:0] ChSp   = 8'd32;
	localparam logic [7:0] ChTil  = 8'd126;
	localparam logic [7:0] ChBrk  = 8'h5B;
	localparam logic [7:0] ChD    = 8'h44;
	localparam logic [7:0] ChC    = 8'h43;
	localparam logic [7:0] ChH    = 8'h48;
	localparam logic [7:0] ChF    = 8'h46;
	localparam logic [7:0] Ch3    = 8'h33;

	localparam logic [1:0] KindEcho = 2'd0;
	localparam logic [1:0] KindChar = 2'd1;
	localparam logic [1:0] KindEol  = 2'd2;

	typedef enum logic [1:0] {
		ESC_IDLE = 2'd0,
		ESC_SEEN = 2'd1,
		ESC_CSI  = 2'd2,
		ESC_CSI3 = 2'd3
	} esc_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD,
		ST_SHR,
		ST_SHR_WR,
		ST_INS_ECHO,
		ST_INS_BS,
		ST_BS_ONE,
		ST_SHL,
		ST_SHL_WR,
		ST_RM_ECHO,
		ST_RM_SP,
		ST_RM_BS,
		ST_RIGHT,
		ST_HOME,
		ST_END,
		ST_LINE,
		ST_EOL
	} state_t;

endpackage

/* hdl/terminal_line_editor_unit.sv */
// Terminal line editor: takes one received byte per input beat and answers with echo
// beats (kind 0), committed line characters (kind 1) and an end-of-line beat (kind 2);
// tlast marks the final beat of each input byte, and bytes that cause nothing give no
// beat. Each byte is handled by a small sequencer that walks the line one entry at a time
// through a line store with a registered read: shifting for insert or delete reads and
// then writes each moved character, and a beat that carries a stored character is read
// from the store before it is output. With D the lesser of LINE_DEPTH and 32, a line
// holds at most one character less than the lesser of D and the capacity register;
// s_tready is low while a byte is in work, also while m_tready is held low and a beat
// waits, so no new byte is taken before the last one is done. The capacity register
// is written through cfg_we/cfg_wdata and should only be written while the block is idle.
module terminal_line_editor_unit
	import tle_pkg::*;
#(
	parameter int LINE_DEPTH = LineDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // out_byte[7:0], line_length[12:8]
	output logic [1:0]  m_tuser,    // kind[1:0]
	output logic        m_tlast
);

	localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int CW = $clog2(LINE_DEPTH + 1) + 1;
	localparam int EffDepth = (LINE_DEPTH < 32) ? LINE_DEPTH : 32;
	// marks held in ch_q for a lone backspace beat
	localparam logic [7:0] MarkErase = 8'd0;
	localparam logic [7:0] MarkArrow = 8'd1;

	state_t state_q, state_d, ret_q, ret_d;
	esc_t   esc_q, esc_d;
	logic [5:0]  cap_q;
	logic [CW-1:0] cnt_q, cnt_d, cur_q, cur_d, idx_q, idx_d;
	logic [CW-1:0] idx_nx, idx_pv, cur_nx;
	logic [7:0]  ch_q, ch_d;
	logic [7:0]  mem [LINE_DEPTH];
	logic [7:0]  rdata_q;
	logic        we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]  wdata;
	logic        ov_q;
	logic [1:0]  okind_q, okind_d;
	logic [7:0]  obyte_q, obyte_d;
	logic [4:0]  olen_q, olen_d;
	logic        olast_q, olast_d;
	logic        oload;
	logic [CW-1:0] effcap;

	// output stage can be loaded when empty or draining
	logic ofree;
	assign ofree = !ov_q || m_tready;

	assign idx_nx = idx_q + CW'(1);
	assign idx_pv = idx_q - CW'(1);
	assign cur_nx = cur_q + CW'(1);

	// effective capacity: least of register and depth
	always_comb begin
		effcap = (CW'(cap_q) > CW'(EffDepth)) ? CW'(EffDepth) : CW'(cap_q);
	end

	// line store port control
	always_comb begin
		we = ((state_q == ST_SHR) && (idx_q == cur_q)) || (state_q == ST_SHR_WR) ||
			(state_q == ST_SHL_WR);
		wdata = (state_q == ST_SHR) ? ch_q : rdata_q;
		waddr = idx_q[AW-1:0];
		case (state_q)
			ST_SHR:  raddr = idx_pv[AW-1:0];
			ST_SHL:  raddr = idx_nx[AW-1:0];
			default: raddr = idx_q[AW-1:0];
		endcase
	end

	// line store with registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// sequencer outputs
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		oload = ofree && (state_q inside {ST_INS_ECHO, ST_INS_BS, ST_BS_ONE, ST_RM_ECHO,
			ST_RM_SP, ST_RM_BS, ST_RIGHT, ST_HOME, ST_END, ST_LINE, ST_EOL});
		okind_d = KindEcho;
		obyte_d = ChBs;
		olen_d  = '0;
		olast_d = 1'b0;
		case (state_q)
			ST_INS_ECHO: begin
				obyte_d = rdata_q;
				olast_d = (idx_nx >= cnt_q) && (cur_nx >= cnt_q);
			end
			ST_INS_BS: olast_d = (idx_nx >= cnt_q);
			ST_BS_ONE: olast_d = ch_q[0];
			ST_RM_ECHO: obyte_d = rdata_q;
			ST_RM_SP: obyte_d = ChSp;
			ST_RM_BS: olast_d = (idx_q >= cnt_q);
			ST_RIGHT: begin
				case (idx_q[1:0])
					2'd0: obyte_d = ChEsc;
					2'd1: obyte_d = ChBrk;
					default: begin
						obyte_d = ChC;
						olast_d = 1'b1;
					end
				endcase
			end
			ST_HOME: olast_d = (cur_q == CW'(1));
			ST_END: begin
				obyte_d = rdata_q;
				olast_d = (idx_nx >= cnt_q);
			end
			ST_LINE: begin
				okind_d = KindChar;
				obyte_d = rdata_q;
			end
			ST_EOL: begin
				okind_d = KindEol;
				obyte_d = ChLf;
				olen_d  = 5'(cnt_q);
				olast_d = 1'b1;
			end
			default: ;
		endcase
	end

	// sequencer next state and line bookkeeping
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		esc_d   = esc_q;
		cnt_d   = cnt_q;
		cur_d   = cur_q;
		idx_d   = idx_q;
		ch_d    = ch_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					ch_d = s_tdata;
					case (esc_q)
						ESC_SEEN: esc_d = (s_tdata == ChBrk) ? ESC_CSI : ESC_IDLE;
						ESC_CSI: begin
							esc_d = (s_tdata == Ch3) ? ESC_CSI3 : ESC_IDLE;
							if (s_tdata == ChD && cur_q != '0) begin
								cur_d = cur_q - CW'(1);
								ch_d = MarkArrow;
								state_d = ST_BS_ONE;
							end else if (s_tdata == ChC && cur_q < cnt_q) begin
								cur_d = cur_nx;
								idx_d = '0;
								state_d = ST_RIGHT;
							end else if (s_tdata == ChH && cur_q != '0) begin
								state_d = ST_HOME;
							end else if (s_tdata == ChF && cur_q < cnt_q) begin
								idx_d = cur_q;
								ret_d = ST_END;
								state_d = ST_RD;
							end
						end
						ESC_CSI3: begin
							esc_d = ESC_IDLE;
							if (s_tdata == ChTil && cur_q < cnt_q) begin
								idx_d = cur_q;
								state_d = ST_SHL;
							end
						end
						default: begin
							if (s_tdata == ChEsc) esc_d = ESC_SEEN;
							else if (s_tdata inside {[ChSp:ChTil]}) begin
								if (effcap != '0 && cnt_q < effcap - CW'(1)) begin
									idx_d = cnt_q;
									state_d = ST_SHR;
								end
							end else if (s_tdata inside {ChDel, ChBs}) begin
								if (cur_q != '0) begin
									cur_d = cur_q - CW'(1);
									ch_d = MarkErase;
									state_d = ST_BS_ONE;
								end
							end else if (s_tdata inside {ChLf, ChCr}) begin
								idx_d = '0;
								if (cnt_q != '0) begin
									ret_d = ST_LINE;
									state_d = ST_RD;
								end else state_d = ST_EOL;
							end
						end
					endcase
				end
			end
			// wait here for the store read, then go to the consuming state
			ST_RD: state_d = ret_q;
			// shift right: read idx-1 here, write idx next, down to the cursor
			ST_SHR: begin
				if (idx_q == cur_q) begin
					cnt_d = cnt_q + CW'(1);
					ret_d = ST_INS_ECHO;
					state_d = ST_RD;
				end else state_d = ST_SHR_WR;
			end
			ST_SHR_WR: begin
				idx_d = idx_pv;
				state_d = ST_SHR;
			end
			ST_INS_ECHO: begin
				if (oload) begin
					if (idx_nx >= cnt_q) begin
						cur_d = cur_nx;
						idx_d = cur_nx;
						state_d = (cur_nx >= cnt_q) ? ST_IDLE : ST_INS_BS;
					end else begin
						idx_d = idx_nx;
						ret_d = ST_INS_ECHO;
						state_d = ST_RD;
					end
				end
			end
			ST_INS_BS: begin
				if (oload) begin
					idx_d = idx_nx;
					if (idx_nx >= cnt_q) state_d = ST_IDLE;
				end
			end
			ST_BS_ONE: begin
				if (oload) begin
					if (ch_q[0]) state_d = ST_IDLE;
					else begin
						idx_d = cur_q;
						state_d = ST_SHL;
					end
				end
			end
			// shift left: read idx+1 here, write idx next
			ST_SHL: begin
				if (idx_nx >= cnt_q) begin
					cnt_d = cnt_q - CW'(1);
					idx_d = cur_q;
					if (cur_nx < cnt_q) begin
						ret_d = ST_RM_ECHO;
						state_d = ST_RD;
					end else state_d = ST_RM_SP;
				end else state_d = ST_SHL_WR;
			end
			ST_SHL_WR: begin
				idx_d = idx_nx;
				state_d = ST_SHL;
			end
			ST_RM_ECHO: begin
				if (oload) begin
					idx_d = idx_nx;
					if (idx_nx >= cnt_q) state_d = ST_RM_SP;
					else begin
						ret_d = ST_RM_ECHO;
						state_d = ST_RD;
					end
				end
			end
			ST_RM_SP: begin
				if (oload) begin
					idx_d = cur_q;
					state_d = ST_RM_BS;
				end
			end
			ST_RM_BS: begin
				if (oload) begin
					idx_d = idx_nx;
					if (idx_q >= cnt_q) state_d = ST_IDLE;
				end
			end
			// right arrow echo, three beats
			ST_RIGHT: begin
				if (oload) begin
					idx_d = idx_nx;
					if (idx_q[1:0] == 2'd2) state_d = ST_IDLE;
				end
			end
			ST_HOME: begin
				if (oload) begin
					cur_d = cur_q - CW'(1);
					if (cur_q == CW'(1)) state_d = ST_IDLE;
				end
			end
			ST_END: begin
				if (oload) begin
					idx_d = idx_nx;
					if (idx_nx >= cnt_q) begin
						cur_d = cnt_q;
						state_d = ST_IDLE;
					end else begin
						ret_d = ST_END;
						state_d = ST_RD;
					end
				end
			end
			ST_LINE: begin
				if (oload) begin
					idx_d = idx_nx;
					if (idx_nx >= cnt_q) state_d = ST_EOL;
					else begin
						ret_d = ST_LINE;
						state_d = ST_RD;
					end
				end
			end
			ST_EOL: begin
				if (oload) begin
					cnt_d = '0;
					cur_d = '0;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			esc_q   <= ESC_IDLE;
			cap_q   <= 6'd32;
			cnt_q   <= '0;
			cur_q   <= '0;
			idx_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			esc_q   <= esc_d;
			cnt_q   <= cnt_d;
			cur_q   <= cur_d;
			idx_q   <= idx_d;
			if (cfg_we) cap_q <= cfg_wdata;
			if (oload) ov_q <= 1'b1;
			else if (m_tready) ov_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		ch_q <= ch_d;
		if (oload) begin
			okind_q <= okind_d;
			obyte_q <= obyte_d;
			olen_q  <= olen_d;
			olast_q <= olast_d;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {3'b000, olen_q, obyte_q};
	assign m_tuser  = okind_q;
	assign m_tlast  = olast_q;

endmodule

/* tb/sv/tb.sv */
module tb;
	import tle_pkg::*;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [4:0] len;
		logic       last;
	} beat_t;

	// directed row: byte, typed beat count (-1 means predicted), typed beat
	typedef struct {
		logic [7:0] rx;
		int         n_typed;
		beat_t      typed;
	} key_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [5:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	beat_t    echo_q[$];
	beat_t    fresh_q[$];
	key_row_t key_rows[$];
	int       n_errors;
	int       tx_idle_pct;
	int       rx_idle_pct;
	logic     hold_go;
	logic     hold_seen;
	int       hold_left;

	// editor state as the predictor sees it
	esc_t       esc_ph;
	logic [7:0] line_mem[32];
	int         n_chars;
	int         cur;
	int         cap_reg;

	terminal_line_editor_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin
		#20000000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report(input string what);
		$display("mismatch: %s", what);
		n_errors++;
	endtask

	function automatic void emit_beat(input logic [1:0] k, input logic [7:0] b,
			input int l);
		if (fresh_q.size() < 64)
			fresh_q.push_back('{k, b, l[4:0], 1'b0});
	endfunction

	function automatic void cut_char(input int pos);
		for (int i = pos; i + 1 < n_chars; i++)
			line_mem[i] = line_mem[i + 1];
		n_chars--;
		for (int i = cur; i < n_chars; i++)
			emit_beat(KindEcho, line_mem[i], 0);
		emit_beat(KindEcho, ChSp, 0);
		for (int i = cur; i < n_chars + 1; i++)
			emit_beat(KindEcho, ChBs, 0);
	endfunction

	function automatic void cursor_key(input logic [7:0] c);
		if (c == ChD) begin
			if (cur > 0) begin
				cur--;
				emit_beat(KindEcho, ChBs, 0);
			end
		end else if (c == ChC) begin
			if (cur < n_chars) begin
				cur++;
				emit_beat(KindEcho, ChEsc, 0);
				emit_beat(KindEcho, ChBrk, 0);
				emit_beat(KindEcho, ChC, 0);
			end
		end else if (c == ChH) begin
			while (cur > 0) begin
				emit_beat(KindEcho, ChBs, 0);
				cur--;
			end
		end else if (c == ChF) begin
			for (int i = cur; i < n_chars; i++)
				emit_beat(KindEcho, line_mem[i], 0);
			cur = n_chars;
		end
	endfunction

	// works out the beats one received byte causes, into fresh_q
	function automatic void edit_line(input logic [7:0] c);
		int eff;
		fresh_q.delete();
		eff = (cap_reg > 32) ? 32 : cap_reg;
		case (esc_ph)
			ESC_SEEN: esc_ph = (c == ChBrk) ? ESC_CSI : ESC_IDLE;
			ESC_CSI: begin
				if (c == Ch3) esc_ph = ESC_CSI3;
				else begin
					esc_ph = ESC_IDLE;
					cursor_key(c);
				end
			end
			ESC_CSI3: begin
				esc_ph = ESC_IDLE;
				if (c == ChTil && cur < n_chars)
					cut_char(cur);
			end
			default: begin
				if (c == ChEsc) esc_ph = ESC_SEEN;
				else if (c >= ChSp && c <= ChTil) begin
					if (eff > 0 && n_chars < eff - 1) begin
						for (int i = n_chars; i > cur; i--)
							line_mem[i] = line_mem[i - 1];
						line_mem[cur] = c;
						n_chars++;
						cur++;
						for (int i = cur - 1; i < n_chars; i++)
							emit_beat(KindEcho, line_mem[i], 0);
						for (int i = cur; i < n_chars; i++)
							emit_beat(KindEcho, ChBs, 0);
					end
				end else if (c == ChDel || c == ChBs) begin
					if (cur > 0) begin
						emit_beat(KindEcho, ChBs, 0);
						cur--;
						cut_char(cur);
					end
				end else if (c == ChLf || c == ChCr) begin
					for (int i = 0; i < n_chars; i++)
						emit_beat(KindChar, line_mem[i], 0);
					emit_beat(KindEol, ChLf, n_chars);
					n_chars = 0;
					cur = 0;
				end
			end
		endcase
		if (fresh_q.size() > 0)
			fresh_q[fresh_q.size() - 1].last = 1'b1;
	endfunction

	// offer one byte, wait for the beat, then queue what it should cause
	task automatic send_byte(input logic [7:0] b, input int n_typed = -1,
			input beat_t typed = '0);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		edit_line(b);
		if (n_typed < 0)
			foreach (fresh_q[i]) echo_q.push_back(fresh_q[i]);
		else if (n_typed == 1)
			echo_q.push_back(typed);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		wait (echo_q.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [5:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_reg = v;
	endtask

	task automatic send_seq(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		send_byte(a);
		send_byte(b);
		send_byte(c);
	endtask

	// mostly well-formed editing, some noise and broken escapes
	task automatic send_token(output int n_sent);
		int r;
		r = $urandom_range(99);
		n_sent = 1;
		if (r < 55) send_byte(8'($urandom_range(32, 126)));
		else if (r < 63) send_byte($urandom_range(1) ? ChDel : ChBs);
		else if (r < 80) begin
			case ($urandom_range(4))
				0: send_seq(ChEsc, ChBrk, ChC);
				1: send_seq(ChEsc, ChBrk, ChD);
				2: send_seq(ChEsc, ChBrk, ChH);
				3: send_seq(ChEsc, ChBrk, ChF);
				default: begin
					send_seq(ChEsc, ChBrk, Ch3);
					send_byte(ChTil);
					n_sent++;
				end
			endcase
			n_sent += 2;
		end else if (r < 88) send_byte($urandom_range(1) ? ChCr : ChLf);
		else if (r < 95) send_byte(8'($urandom_range(255)));
		else begin
			send_seq(ChEsc, $urandom_range(1) ? ChBrk : 8'($urandom_range(255)),
				8'($urandom_range(255)));
			n_sent = 3;
		end
	endtask

	function automatic void add_row(input logic [7:0] b, input int n,
			input logic [1:0] k = KindEcho, input logic [7:0] d = 8'd0,
			input int l = 0);
		key_row_t row;
		row.rx = b;
		row.n_typed = n;
		row.typed = '{k, d, l[4:0], 1'b1};
		key_rows.push_back(row);
	endfunction

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_seen <= 1'b0;
			hold_left <= 0;
		end else if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= 600;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// compare each output beat with the oldest expected one
	always @(posedge clk) begin
		beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (echo_q.size() == 0)
				report($sformatf("unexpected beat data %h user %h", m_tdata, m_tuser));
			else begin
				want = echo_q.pop_front();
				if (m_tuser !== want.kind)
					report($sformatf("kind %0d, want %0d", m_tuser, want.kind));
				if (m_tdata[7:0] !== want.data)
					report($sformatf("byte %h, want %h", m_tdata[7:0], want.data));
				if (m_tdata[12:8] !== want.len)
					report($sformatf("length %0d, want %0d", m_tdata[12:8], want.len));
				if (m_tlast !== want.last)
					report($sformatf("last %b, want %b", m_tlast, want.last));
			end
		end
	end

	initial begin
		int n_sent;
		int n_bytes;
		logic [5:0] caps[7] = '{6'd2, 6'd0, 6'd1, 6'd6, 6'd63, 6'd17, 6'd32};
		n_errors = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_go = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		esc_ph = ESC_IDLE;
		foreach (line_mem[i]) line_mem[i] = '0;
		n_chars = 0;
		cur = 0;
		cap_reg = 32;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-line cases, edits, escapes and stray bytes
		add_row(ChCr, 1, KindEol, ChLf, 0);
		add_row(ChBs, 0);
		add_row(ChEsc, 0); add_row(ChBrk, 0); add_row(ChD, 0);
		add_row(ChSp, -1); add_row(ChTil, -1); add_row("A", -1);
		add_row(ChEsc, 0); add_row(ChBrk, 0); add_row(ChH, -1);
		add_row(ChEsc, 0); add_row(ChBrk, 0); add_row(Ch3, 0); add_row(ChTil, -1);
		add_row(ChEsc, 0); add_row(ChBrk, 0); add_row(ChF, -1);
		add_row(ChEsc, 0); add_row(ChBrk, 0); add_row(ChC, 0);
		add_row(ChEsc, 0); add_row(ChBrk, 0); add_row(Ch3, 0); add_row(ChTil, 0);
		add_row(8'hFF, 0); add_row(8'h00, 0); add_row(ChDel, -1);
		add_row(ChEsc, 0); add_row("x", 0);
		add_row(ChEsc, 0); add_row(ChBrk, 0); add_row("A", 0);
		add_row(ChEsc, 0); add_row(ChBrk, 0); add_row(Ch3, 0); add_row(ChCr, 0);
		add_row(ChLf, -1);
		foreach (key_rows[i])
			send_byte(key_rows[i].rx, key_rows[i].n_typed, key_rows[i].typed);

		// random phases, one capacity each, lines may be left open across writes
		for (int p = 0; p < 7; p++) begin
			settle();
			set_capacity(caps[p]);
			tx_idle_pct <= (p < 2) ? 33 : (p < 4) ? 87 : 0;
			rx_idle_pct <= (p < 2) ? 87 : (p < 4) ? 33 : 0;
			if (p == 4) hold_go <= ~hold_go;
			n_bytes = 0;
			while (n_bytes < 13) begin
				send_token(n_sent);
				n_bytes += n_sent;
			end
		end

		settle();
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
